>>> sv/gass_pkg.sv
// ----------------------------------------------------------------------------
// gass_pkg: shared types and constants of the graph adjacency state store
// Field widths, command codes, the decoded operation and the command record
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package gass_pkg;

  localparam int CMD_W  = 3;
  localparam int VID_W  = 6;
  localparam int SV_W   = 8;
  localparam int DEG_W  = 7;
  localparam int EDGE_W = 12;
  localparam int VCNT_W = 7;

  // Number of vertices that the vertex index fields can name.
  localparam int ADDR_SPACE = 1 << VID_W;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE_EDGE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY_EDGE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_VERT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_PEND  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COMMIT      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd6;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_WRITE,
    OP_COMMIT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             a_ok;
    logic             b_ok;
    logic [VID_W-1:0] ia;
    logic [VID_W-1:0] ib;
    logic [SV_W-1:0]  sv;
  } cmd_t;

endpackage

>>> sv/gass_front.sv
// ----------------------------------------------------------------------------
// gass_front: command intake and classification
// Checks the vertex indexes against the slot count and turns each command
// into the operation that the back end really has to carry out.
// ----------------------------------------------------------------------------
module gass_front
  import gass_pkg::*;
#(
  parameter int VERTEX_SLOTS = 64
) (
  input  logic [CMD_W-1:0] command_i,
  input  logic [VID_W-1:0] vertex_a_i,
  input  logic [VID_W-1:0] vertex_b_i,
  input  logic [SV_W-1:0]  state_value_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output cmd_t             push_cmd_o
);

  logic a_ok;
  logic b_ok;
  op_e  op;

  assign a_ok = 32'(vertex_a_i) < VERTEX_SLOTS;
  assign b_ok = 32'(vertex_b_i) < VERTEX_SLOTS;

  // Commands that cannot change anything are reduced to a plain query.
  always_comb begin
    case (command_i)
      CMD_ADD_EDGE:    op = (a_ok && b_ok) ? OP_ADD : OP_QUERY;
      CMD_REMOVE_EDGE: op = (a_ok && b_ok) ? OP_REMOVE : OP_QUERY;
      CMD_WRITE_PEND:  op = a_ok ? OP_WRITE : OP_QUERY;
      CMD_COMMIT:      op = OP_COMMIT;
      CMD_CLEAR:       op = OP_CLEAR;
      default:         op = OP_QUERY;
    endcase
  end

  always_comb begin
    push_cmd_o.op   = op;
    push_cmd_o.a_ok = a_ok;
    push_cmd_o.b_ok = b_ok;
    push_cmd_o.ia   = a_ok ? vertex_a_i : '0;
    push_cmd_o.ib   = b_ok ? vertex_b_i : '0;
    push_cmd_o.sv   = state_value_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

>>> sv/gass_queue.sv
// ----------------------------------------------------------------------------
// gass_queue: two-entry command queue
// Decouples command intake from execution so that each side stalls on its own.
// ----------------------------------------------------------------------------
module gass_queue
  import gass_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> sv/gass_back.sv
// ----------------------------------------------------------------------------
// gass_back: command execution engine
// Holds the adjacency, degree and state memories, runs the read-modify-write
// and sweep sequences, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module gass_back
  import gass_pkg::*;
#(
  parameter int VERTEX_SLOTS = 64,
  parameter int STATE_BITS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SV_W-1:0]   init_state_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  cmd_t              pop_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              edge_present_o,
  output logic              changed_o,
  output logic              vertex_present_o,
  output logic [DEG_W-1:0]  degree_o,
  output logic [SV_W-1:0]   vertex_state_o,
  output logic [EDGE_W-1:0] edge_count_o,
  output logic [VCNT_W-1:0] vertex_count_o
);

  // Only the slots that an index field can name ever hold anything.
  localparam int SLOTS = (VERTEX_SLOTS < ADDR_SPACE) ? VERTEX_SLOTS : ADDR_SPACE;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RD_A    = 4'd1;
  localparam logic [3:0] ST_RD_B    = 4'd2;
  localparam logic [3:0] ST_WR_A    = 4'd3;
  localparam logic [3:0] ST_WR_B    = 4'd4;
  localparam logic [3:0] ST_PEND    = 4'd5;
  localparam logic [3:0] ST_CMT     = 4'd6;
  localparam logic [3:0] ST_CMT_END = 4'd7;
  localparam logic [3:0] ST_CLR     = 4'd8;
  localparam logic [3:0] ST_RPT_RD  = 4'd9;
  localparam logic [3:0] ST_RPT     = 4'd10;

  logic [3:0]            state_q;
  cmd_t                  cur_q;
  logic                  changed_q;
  logic [IDX_W-1:0]      sweep_q;
  logic                  cmt_wr_q;
  logic [IDX_W-1:0]      cmt_idx_q;
  logic [STATE_BITS-1:0] init_snap_q;

  // Memories and their per-entry valid bits.
  logic [SLOTS-1:0]      row_mem [SLOTS];
  logic [DEG_W-1:0]      deg_mem [SLOTS];
  logic [STATE_BITS-1:0] cm_mem  [SLOTS];
  logic [STATE_BITS-1:0] pd_mem  [SLOTS];
  logic [SLOTS-1:0]      gr_vld_q;
  logic [SLOTS-1:0]      cm_vld_q;
  logic [SLOTS-1:0]      pd_vld_q;
  logic [SLOTS-1:0]      row_rd_q;
  logic [DEG_W-1:0]      deg_rd_q;
  logic [STATE_BITS-1:0] cm_rd_q;
  logic [STATE_BITS-1:0] pd_rd_q;
  logic                  gr_rd_vld_q;
  logic                  cm_rd_vld_q;
  logic                  pd_rd_vld_q;

  logic [SLOTS-1:0]      present_q;
  logic [EDGE_W-1:0]     edges_q;
  logic [VCNT_W-1:0]     vcnt_q;

  logic [SLOTS-1:0]      hold_row_q;
  logic [DEG_W-1:0]      hold_deg_q;
  logic [SLOTS-1:0]      b_row_q;
  logic [DEG_W-1:0]      b_deg_q;

  logic                  out_valid_q;
  logic                  out_edge_q;
  logic                  out_chg_q;
  logic                  out_vpres_q;
  logic [DEG_W-1:0]      out_deg_q;
  logic [SV_W-1:0]       out_state_q;
  logic [EDGE_W-1:0]     out_edges_q;
  logic [VCNT_W-1:0]     out_vcnt_q;

  logic [IDX_W-1:0]      a_idx;
  logic [IDX_W-1:0]      b_idx;
  logic                  is_add;
  logic [SLOTS-1:0]      row_eff;
  logic [DEG_W-1:0]      deg_eff;
  logic [STATE_BITS-1:0] cm_eff;
  logic [STATE_BITS-1:0] pd_eff;
  logic                  do_chg;
  logic [SLOTS-1:0]      new_row_a;
  logic [DEG_W-1:0]      new_deg_a;
  logic [SLOTS-1:0]      base_row;
  logic [DEG_W-1:0]      base_deg;
  logic [SLOTS-1:0]      new_row_b;
  logic [DEG_W-1:0]      new_deg_b;
  logic [IDX_W-1:0]      gr_ra;
  logic                  gr_we;
  logic [IDX_W-1:0]      gr_wa;
  logic [SLOTS-1:0]      gr_wrow;
  logic [DEG_W-1:0]      gr_wdeg;
  logic                  pd_we;
  logic                  cm_we;
  logic                  pop;
  logic                  out_load;
  logic [SV_W+STATE_BITS-1:0] sv_ext;
  logic [SV_W+STATE_BITS-1:0] init_ext;
  logic [SV_W+STATE_BITS-1:0] cm_ext;

  assign a_idx  = cur_q.ia[IDX_W-1:0];
  assign b_idx  = cur_q.ib[IDX_W-1:0];
  assign is_add = (cur_q.op == OP_ADD);

  // Entries that were never written since reset or clear read as reset values.
  assign row_eff = gr_rd_vld_q ? row_rd_q : '0;
  assign deg_eff = gr_rd_vld_q ? deg_rd_q : '0;
  assign cm_eff  = cm_rd_vld_q ? cm_rd_q : init_snap_q;
  assign pd_eff  = pd_rd_vld_q ? pd_rd_q : init_snap_q;

  // Width adaptation between the 8-bit ports and the stored state width.
  assign sv_ext   = {{STATE_BITS{1'b0}}, cur_q.sv};
  assign init_ext = {{STATE_BITS{1'b0}}, init_state_i};
  assign cm_ext   = {{SV_W{1'b0}}, cm_eff};

  // Edge update. In the write-a cycle the row of b is on the read port; a
  // self-loop builds the second update on top of the first one.
  always_comb begin
    do_chg             = is_add ? !hold_row_q[b_idx] : hold_row_q[b_idx];
    new_row_a          = hold_row_q;
    new_row_a[b_idx]   = is_add;
    new_deg_a          = is_add ? hold_deg_q + DEG_W'(1) : hold_deg_q - DEG_W'(1);
    base_row           = (a_idx == b_idx) ? new_row_a : row_eff;
    base_deg           = (a_idx == b_idx) ? new_deg_a : deg_eff;
    new_row_b          = base_row;
    new_row_b[a_idx]   = is_add;
    new_deg_b          = is_add ? base_deg + DEG_W'(1) : base_deg - DEG_W'(1);
  end

  always_comb begin
    gr_ra   = (state_q == ST_RD_B) ? b_idx : a_idx;
    gr_we   = 1'b0;
    gr_wa   = a_idx;
    gr_wrow = new_row_a;
    gr_wdeg = new_deg_a;
    if (state_q == ST_WR_A) begin
      gr_we = do_chg;
    end else if (state_q == ST_WR_B) begin
      gr_we   = 1'b1;
      gr_wa   = b_idx;
      gr_wrow = b_row_q;
      gr_wdeg = b_deg_q;
    end
  end

  assign pd_we       = (state_q == ST_PEND);
  assign cm_we       = cmt_wr_q && present_q[cmt_idx_q];
  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_load    = (state_q == ST_RPT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    row_rd_q <= row_mem[gr_ra];
    deg_rd_q <= deg_mem[gr_ra];
    if (gr_we) begin
      row_mem[gr_wa] <= gr_wrow;
      deg_mem[gr_wa] <= gr_wdeg;
    end
  end

  always_ff @(posedge clk_i) begin
    cm_rd_q <= cm_mem[a_idx];
    if (cm_we) cm_mem[cmt_idx_q] <= pd_eff;
  end

  always_ff @(posedge clk_i) begin
    pd_rd_q <= pd_mem[sweep_q];
    if (pd_we) pd_mem[a_idx] <= sv_ext[STATE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= pop_cmd_i;
    if (state_q == ST_RD_B) begin
      hold_row_q <= row_eff;
      hold_deg_q <= deg_eff;
    end
    if (state_q == ST_WR_A) begin
      b_row_q <= new_row_b;
      b_deg_q <= new_deg_b;
    end
    cmt_idx_q <= sweep_q;
    if (out_load) begin
      out_edge_q  <= cur_q.a_ok && cur_q.b_ok && row_eff[b_idx];
      out_chg_q   <= changed_q;
      out_vpres_q <= cur_q.a_ok && present_q[a_idx];
      out_deg_q   <= cur_q.a_ok ? deg_eff : '0;
      out_state_q <= cur_q.a_ok ? cm_ext[SV_W-1:0] : '0;
      out_edges_q <= edges_q;
      out_vcnt_q  <= vcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      changed_q   <= 1'b0;
      sweep_q     <= '0;
      cmt_wr_q    <= 1'b0;
      init_snap_q <= '0;
      gr_vld_q    <= '0;
      cm_vld_q    <= '0;
      pd_vld_q    <= '0;
      gr_rd_vld_q <= 1'b0;
      cm_rd_vld_q <= 1'b0;
      pd_rd_vld_q <= 1'b0;
      present_q   <= '0;
      edges_q     <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gr_rd_vld_q <= gr_vld_q[gr_ra];
      cm_rd_vld_q <= cm_vld_q[a_idx];
      pd_rd_vld_q <= pd_vld_q[sweep_q];
      cmt_wr_q    <= (state_q == ST_CMT);
      if (gr_we) gr_vld_q[gr_wa] <= 1'b1;
      if (pd_we) pd_vld_q[a_idx] <= 1'b1;
      if (cm_we) cm_vld_q[cmt_idx_q] <= 1'b1;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            changed_q <= 1'b0;
            sweep_q   <= '0;
            case (pop_cmd_i.op)
              OP_ADD, OP_REMOVE: state_q <= ST_RD_A;
              OP_WRITE:          state_q <= ST_PEND;
              OP_COMMIT:         state_q <= ST_CMT;
              OP_CLEAR:          state_q <= ST_CLR;
              default:           state_q <= ST_RPT_RD;
            endcase
          end
        end
        ST_RD_A: state_q <= ST_RD_B;
        ST_RD_B: state_q <= ST_WR_A;
        ST_WR_A: begin
          changed_q <= do_chg;
          if (do_chg) begin
            edges_q <= is_add ? edges_q + EDGE_W'(1) : edges_q - EDGE_W'(1);
            if (is_add && !present_q[a_idx]) begin
              present_q[a_idx] <= 1'b1;
              vcnt_q           <= vcnt_q + VCNT_W'(1);
            end else if (!is_add && new_deg_a == '0 && present_q[a_idx]) begin
              present_q[a_idx] <= 1'b0;
              vcnt_q           <= vcnt_q - VCNT_W'(1);
            end
            state_q <= ST_WR_B;
          end else begin
            state_q <= ST_RPT_RD;
          end
        end
        ST_WR_B: begin
          if (is_add && !present_q[b_idx]) begin
            present_q[b_idx] <= 1'b1;
            vcnt_q           <= vcnt_q + VCNT_W'(1);
          end else if (!is_add && b_deg_q == '0 && present_q[b_idx]) begin
            present_q[b_idx] <= 1'b0;
            vcnt_q           <= vcnt_q - VCNT_W'(1);
          end
          state_q <= ST_RPT_RD;
        end
        ST_PEND: state_q <= ST_RPT_RD;
        ST_CMT: begin
          if (sweep_q == IDX_W'(SLOTS - 1)) begin
            state_q <= ST_CMT_END;
          end else begin
            sweep_q <= sweep_q + IDX_W'(1);
          end
        end
        ST_CMT_END: state_q <= ST_RPT_RD;
        ST_CLR: begin
          gr_vld_q    <= '0;
          cm_vld_q    <= '0;
          pd_vld_q    <= '0;
          present_q   <= '0;
          edges_q     <= '0;
          vcnt_q      <= '0;
          init_snap_q <= init_ext[STATE_BITS-1:0];
          state_q     <= ST_RPT_RD;
        end
        ST_RPT_RD: state_q <= ST_RPT;
        ST_RPT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_present_o   = out_edge_q;
  assign changed_o        = out_chg_q;
  assign vertex_present_o = out_vpres_q;
  assign degree_o         = out_deg_q;
  assign vertex_state_o   = out_state_q;
  assign edge_count_o     = out_edges_q;
  assign vertex_count_o   = out_vcnt_q;

endmodule

>>> sv/graph_adjacency_state_store_top.sv
// ----------------------------------------------------------------------------
// graph_adjacency_state_store_top: undirected graph store with vertex states
// Adjacency matrix, degrees, presence and double-buffered vertex states behind
// a command channel and a result channel.
// ----------------------------------------------------------------------------
// Every accepted command produces exactly one result transfer that reports
// vertex_a, the pair (vertex_a, vertex_b) and the graph totals as they stand
// after the command. Commands are executed one at a time by a sequencer in the
// back end, and the steps per command are set by the single read port of each
// memory: an add or remove that changes the graph does two row reads, then two
// row writes, then the result read, one that changes nothing does no writes,
// and a commit sweeps the pending-state memory one slot per cycle. A two-entry
// queue in front of the sequencer keeps taking commands while one is at work,
// and the result register lets the next command start while a result still
// waits to be taken. Clear takes effect at once through per-slot valid bits,
// so there is no clearing pass after reset or clear; it loads the initial_state
// value written before it.
// ----------------------------------------------------------------------------
module graph_adjacency_state_store_top
  import gass_pkg::*;
#(
  parameter int VERTEX_SLOTS = 64,
  parameter int STATE_BITS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: initial_state register.
  input  logic              cfg_we_i,
  input  logic [SV_W-1:0]   cfg_wdata_i,
  // Command channel.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [VID_W-1:0]  vertex_a_i,
  input  logic [VID_W-1:0]  vertex_b_i,
  input  logic [SV_W-1:0]   state_value_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              edge_present_o,
  output logic              changed_o,
  output logic              vertex_present_o,
  output logic [DEG_W-1:0]  degree_o,
  output logic [SV_W-1:0]   vertex_state_o,
  output logic [EDGE_W-1:0] edge_count_o,
  output logic [VCNT_W-1:0] vertex_count_o
);

  logic [SV_W-1:0] init_state_q;
  logic            push_valid;
  logic            push_ready;
  cmd_t            push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  cmd_t            pop_cmd;

  // The initial_state register is only read when a clear executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_state_q <= '0;
    end else if (cfg_we_i) begin
      init_state_q <= cfg_wdata_i;
    end
  end

  // The front end checks the indexes and reduces commands that cannot change
  // anything to queries.
  gass_front #(
    .VERTEX_SLOTS (VERTEX_SLOTS)
  ) u_front (
    .command_i     (command_i),
    .vertex_a_i    (vertex_a_i),
    .vertex_b_i    (vertex_b_i),
    .state_value_i (state_value_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  // The queue lets intake continue while the back end is busy.
  gass_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // The back end owns all graph state and the result register.
  gass_back #(
    .VERTEX_SLOTS (VERTEX_SLOTS),
    .STATE_BITS   (STATE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .init_state_i     (init_state_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_cmd_i        (pop_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_present_o   (edge_present_o),
    .changed_o        (changed_o),
    .vertex_present_o (vertex_present_o),
    .degree_o         (degree_o),
    .vertex_state_o   (vertex_state_o),
    .edge_count_o     (edge_count_o),
    .vertex_count_o   (vertex_count_o)
  );

endmodule

>>> tb/tb_graph_adjacency_state_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_adjacency_state_store_top: self-checking bench of the graph store
// A short table of commands with hand-written results for the easy cases is
// followed by several phases of random commands under different
// initial_state settings. A behavioral copy of the store predicts every
// result, and the result monitor compares each transfer field by field.
// ----------------------------------------------------------------------------
module tb_graph_adjacency_state_store_top;
  import gass_pkg::*;

  // The package has no name for the unused command code; it must act as a query.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

  localparam int NUM_VERTICES   = 64;
  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  // A commit sweeps every slot, which is the longest a command can run.
  localparam int SETTLE_CYCLES  = NUM_VERTICES + 16;
  localparam int RANDOM_ITEMS   = 300;
  localparam int HOLD_AFTER     = 500;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [CMD_W-1:0] opcode;
    logic [VID_W-1:0] vtx_a;
    logic [VID_W-1:0] vtx_b;
    logic [SV_W-1:0]  value;
  } graph_cmd_t;

  typedef struct packed {
    logic              edge_present;
    logic              changed;
    logic              vertex_present;
    logic [DEG_W-1:0]  degree;
    logic [SV_W-1:0]   vertex_state;
    logic [EDGE_W-1:0] edge_count;
    logic [VCNT_W-1:0] vertex_count;
  } graph_report_t;

  typedef enum logic {ROW_COMMAND, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    graph_cmd_t    item;
    logic          typed;
    graph_report_t report;
    logic [SV_W-1:0] cfg_value;
  } directed_row_t;

  // Every input starts at a known value; reset is held from time zero.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [SV_W-1:0]   cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command_i     = '0;
  logic [VID_W-1:0]  vertex_a_i    = '0;
  logic [VID_W-1:0]  vertex_b_i    = '0;
  logic [SV_W-1:0]   state_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              edge_present_o;
  logic              changed_o;
  logic              vertex_present_o;
  logic [DEG_W-1:0]  degree_o;
  logic [SV_W-1:0]   vertex_state_o;
  logic [EDGE_W-1:0] edge_count_o;
  logic [VCNT_W-1:0] vertex_count_o;

  // Behavioral copy of the store, updated at every accepted command transfer.
  logic [NUM_VERTICES-1:0] adj_rows      [NUM_VERTICES];
  logic [DEG_W-1:0]        vertex_degree [NUM_VERTICES];
  logic                    vertex_live   [NUM_VERTICES];
  logic [SV_W-1:0]         state_now     [NUM_VERTICES];
  logic [SV_W-1:0]         state_next    [NUM_VERTICES];
  logic [EDGE_W-1:0]       edge_total;
  logic [VCNT_W-1:0]       live_total;
  logic [SV_W-1:0]         init_state_model;

  // Results still owed by the block, oldest first.
  graph_report_t expected_reports[$];
  int unsigned   mismatch_count = 0;
  // While set, neither side of the block idles.
  logic          steady = 1'b0;

  graph_adjacency_state_store_top #(
    .VERTEX_SLOTS (NUM_VERTICES),
    .STATE_BITS   (SV_W)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .vertex_a_i       (vertex_a_i),
    .vertex_b_i       (vertex_b_i),
    .state_value_i    (state_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_present_o   (edge_present_o),
    .changed_o        (changed_o),
    .vertex_present_o (vertex_present_o),
    .degree_o         (degree_o),
    .vertex_state_o   (vertex_state_o),
    .edge_count_o     (edge_count_o),
    .vertex_count_o   (vertex_count_o)
  );

  initial begin : clock_gen
    forever begin
      #(CLK_PERIOD / 2) clk_i = ~clk_i;
    end
  end

  // Restores the empty graph; both state buffers take the current initial_state.
  function automatic void wipe_graph();
    for (int v = 0; v < NUM_VERTICES; v++) begin
      adj_rows[v]      = '0;
      vertex_degree[v] = '0;
      vertex_live[v]   = 1'b0;
      state_now[v]     = init_state_model;
      state_next[v]    = init_state_model;
    end
    edge_total = '0;
    live_total = '0;
  endfunction

  // Keeps the live vertex count in step with the presence flags.
  function automatic void mark_live(input logic [VID_W-1:0] v, input logic live);
    if (live && !vertex_live[v]) begin
      vertex_live[v] = 1'b1;
      live_total     = live_total + 1'b1;
    end else if (!live && vertex_live[v]) begin
      vertex_live[v] = 1'b0;
      live_total     = live_total - 1'b1;
    end
  endfunction

  // Applies one command to the copy of the store and returns the report that
  // the block must give for it, taken from the state after the command.
  function automatic graph_report_t predict_report(input graph_cmd_t c);
    graph_report_t r;
    logic          a_ok;
    logic          b_ok;
    logic          pair_ok;
    a_ok    = int'(c.vtx_a) < NUM_VERTICES;
    b_ok    = int'(c.vtx_b) < NUM_VERTICES;
    pair_ok = a_ok && b_ok;
    r       = '0;
    case (c.opcode)
      CMD_ADD_EDGE: begin
        if (pair_ok && !adj_rows[c.vtx_a][c.vtx_b]) begin
          adj_rows[c.vtx_a][c.vtx_b] = 1'b1;
          adj_rows[c.vtx_b][c.vtx_a] = 1'b1;
          // A self-loop passes through both increments and counts twice.
          vertex_degree[c.vtx_a] = vertex_degree[c.vtx_a] + 1'b1;
          vertex_degree[c.vtx_b] = vertex_degree[c.vtx_b] + 1'b1;
          mark_live(c.vtx_a, 1'b1);
          mark_live(c.vtx_b, 1'b1);
          edge_total = edge_total + 1'b1;
          r.changed  = 1'b1;
        end
      end
      CMD_REMOVE_EDGE: begin
        if (pair_ok && adj_rows[c.vtx_a][c.vtx_b]) begin
          adj_rows[c.vtx_a][c.vtx_b] = 1'b0;
          adj_rows[c.vtx_b][c.vtx_a] = 1'b0;
          vertex_degree[c.vtx_a] = vertex_degree[c.vtx_a] - 1'b1;
          vertex_degree[c.vtx_b] = vertex_degree[c.vtx_b] - 1'b1;
          edge_total = edge_total - 1'b1;
          if (vertex_degree[c.vtx_a] == '0) mark_live(c.vtx_a, 1'b0);
          if (vertex_degree[c.vtx_b] == '0) mark_live(c.vtx_b, 1'b0);
          r.changed = 1'b1;
        end
      end
      CMD_WRITE_PEND: begin
        if (a_ok) state_next[c.vtx_a] = c.value;
      end
      CMD_COMMIT: begin
        // Absent vertices keep both their committed and their pending state.
        for (int v = 0; v < NUM_VERTICES; v++) begin
          if (vertex_live[v]) state_now[v] = state_next[v];
        end
      end
      CMD_CLEAR: begin
        wipe_graph();
      end
      default: begin
        // Queries and the undefined code leave the store alone.
      end
    endcase
    r.edge_present   = pair_ok && adj_rows[c.vtx_a][c.vtx_b];
    r.vertex_present = a_ok && vertex_live[c.vtx_a];
    r.degree         = a_ok ? vertex_degree[c.vtx_a] : '0;
    r.vertex_state   = a_ok ? state_now[c.vtx_a] : '0;
    r.edge_count     = edge_total;
    r.vertex_count   = live_total;
    return r;
  endfunction

  // Picks vertices mostly from a small cluster so that adds and removes often
  // find an existing edge, and now and then from the whole index range.
  function automatic logic [VID_W-1:0] pick_vertex();
    if ($urandom_range(99) < 65) return VID_W'($urandom_range(9));
    return VID_W'($urandom_range(NUM_VERTICES - 1));
  endfunction

  function automatic graph_cmd_t random_command();
    graph_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      c.opcode = CMD_ADD_EDGE;
    else if (pick < 52) c.opcode = CMD_REMOVE_EDGE;
    else if (pick < 66) c.opcode = CMD_QUERY_EDGE;
    else if (pick < 76) c.opcode = CMD_QUERY_VERT;
    else if (pick < 88) c.opcode = CMD_WRITE_PEND;
    else if (pick < 96) c.opcode = CMD_COMMIT;
    else if (pick < 97) c.opcode = CMD_CLEAR;
    else                c.opcode = CMD_UNDEFINED;
    c.vtx_a = pick_vertex();
    c.vtx_b = pick_vertex();
    c.value = SV_W'($urandom_range(255));
    return c;
  endfunction

  function automatic directed_row_t cmd_row(input logic [CMD_W-1:0] op,
                                            input int a, input int b, input int v);
    directed_row_t row_d;
    row_d.kind      = ROW_COMMAND;
    row_d.item      = '{opcode: op, vtx_a: VID_W'(a), vtx_b: VID_W'(b), value: SV_W'(v)};
    row_d.typed     = 1'b0;
    row_d.report    = '0;
    row_d.cfg_value = '0;
    return row_d;
  endfunction

  function automatic directed_row_t typed_row(input logic [CMD_W-1:0] op,
                                              input int a, input int b, input int v,
                                              input int ep, input int ch, input int vp,
                                              input int deg, input int st,
                                              input int ec, input int vc);
    directed_row_t row_d;
    row_d        = cmd_row(op, a, b, v);
    row_d.typed  = 1'b1;
    row_d.report = '{edge_present: ep[0], changed: ch[0], vertex_present: vp[0],
                     degree: DEG_W'(deg), vertex_state: SV_W'(st),
                     edge_count: EDGE_W'(ec), vertex_count: VCNT_W'(vc)};
    return row_d;
  endfunction

  function automatic directed_row_t cfg_row(input int v);
    directed_row_t row_d;
    row_d           = cmd_row(CMD_QUERY_VERT, 0, 0, 0);
    row_d.kind      = ROW_CONFIG;
    row_d.cfg_value = SV_W'(v);
    return row_d;
  endfunction

  // Offers one command, holds it until the transfer, then books its result.
  // Where the row carries a hand-written result, that one is expected instead
  // of the predicted one, but the copy of the store is still advanced.
  task automatic send_command(input graph_cmd_t item, input logic typed,
                              input graph_report_t typed_report);
    graph_report_t predicted;
    if (!steady && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= item.opcode;
    vertex_a_i    <= item.vtx_a;
    vertex_b_i    <= item.vtx_b;
    state_value_i <= item.value;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_report(item);
    expected_reports = {expected_reports, (typed ? typed_report : predicted)};
  endtask

  // The register may only change while the block is idle. Every command gives
  // a result, so an empty expectation queue means the sequencer has finished;
  // the extra cycles only add margin.
  task automatic settle_and_configure(input logic [SV_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i         <= 1'b1;
    cfg_wdata_i      <= value;
    init_state_model  = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned actv);
    if (expv != actv) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Result side: checks every transfer against the oldest expectation and
  // drives out_ready_i. After HOLD_AFTER results it holds off for as long as
  // HOLD_CYCLES sets, so that the queue in the block fills and in_ready_o drops
  // while the sender keeps its command on offer.
  initial begin : result_monitor
    graph_report_t want;
    int unsigned   results_seen;
    int unsigned   hold_left;
    results_seen = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t ns: result transfer with no command outstanding", $time);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("edge_present",   want.edge_present,   edge_present_o);
          check_field("changed",        want.changed,        changed_o);
          check_field("vertex_present", want.vertex_present, vertex_present_o);
          check_field("degree",         want.degree,         degree_o);
          check_field("vertex_state",   want.vertex_state,   vertex_state_o);
          check_field("edge_count",     want.edge_count,     edge_count_o);
          check_field("vertex_count",   want.vertex_count,   vertex_count_o);
        end
        results_seen++;
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin : stimulus
    directed_row_t   rows[$];
    graph_cmd_t      item;
    logic [SV_W-1:0] phase_setting[6];
    int              hub;

    init_state_model = '0;
    wipe_graph();

    // Directed part. Hand-written results are only given where they are
    // obvious: the empty store, the first edge, a repeated add and a clear.
    rows = {rows, typed_row(CMD_QUERY_VERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, typed_row(CMD_QUERY_EDGE, 63, 63, 255, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, typed_row(CMD_ADD_EDGE, 0, 63, 0, 1, 1, 1, 1, 0, 1, 2)};
    // The same edge named the other way round is already there.
    rows = {rows, typed_row(CMD_ADD_EDGE, 63, 0, 0, 1, 0, 1, 1, 0, 1, 2)};
    // A self-loop adds two to the degree and one to the edge count.
    rows = {rows, cmd_row(CMD_ADD_EDGE, 63, 63, 0)};
    rows = {rows, cmd_row(CMD_QUERY_VERT, 63, 0, 0)};
    rows = {rows, cmd_row(CMD_WRITE_PEND, 63, 0, 255)};
    // Vertex 5 is absent, so the commit must leave its pending value waiting.
    rows = {rows, cmd_row(CMD_WRITE_PEND, 5, 0, 8'hAA)};
    rows = {rows, cmd_row(CMD_COMMIT, 63, 0, 0)};
    rows = {rows, cmd_row(CMD_QUERY_VERT, 5, 0, 0)};
    rows = {rows, cmd_row(CMD_ADD_EDGE, 5, 6, 0)};
    rows = {rows, cmd_row(CMD_COMMIT, 5, 6, 0)};
    rows = {rows, cmd_row(CMD_REMOVE_EDGE, 63, 63, 0)};
    // The last edge of vertex 63 goes, so it becomes absent.
    rows = {rows, cmd_row(CMD_REMOVE_EDGE, 0, 63, 0)};
    rows = {rows, cmd_row(CMD_REMOVE_EDGE, 0, 63, 0)};
    rows = {rows, cmd_row(CMD_QUERY_EDGE, 6, 5, 0)};
    rows = {rows, cmd_row(CMD_UNDEFINED, 5, 6, 255)};
    rows = {rows, typed_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    // A new setting only shows after the next clear.
    rows = {rows, cfg_row(8'hFF)};
    rows = {rows, typed_row(CMD_QUERY_VERT, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, typed_row(CMD_CLEAR, 63, 63, 0, 0, 0, 0, 0, 8'hFF, 0, 0)};
    rows = {rows, cmd_row(CMD_WRITE_PEND, 1, 0, 0)};
    rows = {rows, cmd_row(CMD_ADD_EDGE, 1, 2, 255)};
    rows = {rows, cmd_row(CMD_COMMIT, 0, 0, 0)};
    rows = {rows, cmd_row(CMD_QUERY_VERT, 1, 2, 0)};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CONFIG) settle_and_configure(rows[i].cfg_value);
      else send_command(rows[i].item, rows[i].typed, rows[i].report);
    end

    // Random phases, each under its own initial_state and opened by a clear
    // so that the new value is loaded. Phase 3 runs without any idling.
    phase_setting[0] = 8'hFF;
    phase_setting[1] = 8'h00;
    phase_setting[2] = SV_W'($urandom_range(1, 254));
    phase_setting[3] = 8'h01;
    phase_setting[4] = 8'h80;
    phase_setting[5] = SV_W'($urandom_range(255));
    for (int p = 0; p < 6; p++) begin
      settle_and_configure(phase_setting[p]);
      steady = (p == 3);
      item = random_command();
      item.opcode = CMD_CLEAR;
      send_command(item, 1'b0, '0);
      if (p == 1) begin
        // One vertex joined to every slot, itself included, reaches the
        // largest degree a vertex can have, since its self-loop counts twice.
        hub = $urandom_range(NUM_VERTICES - 1);
        for (int v = 0; v < NUM_VERTICES; v++) begin
          item = random_command();
          item.opcode = CMD_ADD_EDGE;
          item.vtx_a  = VID_W'(hub);
          item.vtx_b  = VID_W'(v);
          send_command(item, 1'b0, '0);
        end
        item.opcode = CMD_QUERY_VERT;
        send_command(item, 1'b0, '0);
      end
      repeat (RANDOM_ITEMS) send_command(random_command(), 1'b0, '0);
      steady = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    // Any stray result would still show up within one command time.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The whole run takes a few milliseconds of simulated time even with every
  // command a full commit sweep; this bound is several times that.
  initial begin : watchdog
    #15_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
